[rtl/erf_pkg.sv]
package erf_pkg;

  // Sensor geometry; the pixel count must stay a power of two so that the
  // pixel index wraps by dropping upper bits.
  localparam int unsigned Width  = 256;
  localparam int unsigned Height = 256;
  localparam int unsigned Pixels = Width * Height;
  localparam int unsigned PixW   = $clog2(Pixels);

  // Field widths
  localparam int unsigned CoordW  = 8;
  localparam int unsigned StampW  = 32;
  localparam int unsigned RowW    = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // Register reset values
  localparam logic [StampW-1:0] PeriodRst   = 32'd1000;
  localparam logic              PerPolRst   = 1'b1;
  localparam logic [RowW-1:0]   RowWidthRst = 9'd256;

  // Register indexes on the config port
  typedef enum logic [CfgIdxW-1:0] {
    CfgPeriod   = 2'd0,
    CfgPerPol   = 2'd1,
    CfgRowWidth = 2'd2
  } cfg_idx_e;

  // One event, x in the lowest bits
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic              pol;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } event_t;

  localparam int unsigned EvW    = $bits(event_t);
  localparam int unsigned TDataW = ((EvW + 7) / 8) * 8;
  localparam int unsigned PadW   = TDataW - EvW;

endpackage

[rtl/erf_ts_mem.sv]
module erf_ts_mem #(
  parameter int unsigned AddrW = erf_pkg::PixW + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [erf_pkg::StampW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [erf_pkg::StampW-1:0] wr_data_i,
  output logic                      clr_busy_o
);

  localparam int unsigned Depth = 2 ** AddrW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [erf_pkg::StampW-1:0] mem_q [Depth];
  logic [erf_pkg::StampW-1:0] rdata_q;
  logic [AddrW-1:0]           raddr_q;

  logic                       clr_q, clr_d;
  logic [AddrW-1:0]           clr_cnt_q, clr_cnt_d;

  logic                       fwd_v_q, fwd_v_d;
  logic [AddrW-1:0]           fwd_addr_q;
  logic [erf_pkg::StampW-1:0] fwd_data_q;

  logic                       we;
  logic [AddrW-1:0]           wa;
  logic [erf_pkg::StampW-1:0] wd;

  // Clearing pass after reset, one entry a cycle
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end
  end

  // Write port shared by the clearing pass and the update path
  always_comb begin
    we = clr_q | wr_en_i;
    wa = clr_q ? clr_cnt_q : wr_addr_i;
    wd = clr_q ? '0 : wr_data_i;
  end

  // Last update held for a read that raced it
  assign fwd_v_d = clr_q ? 1'b0 : (fwd_v_q | wr_en_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      fwd_v_q   <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      fwd_v_q   <= fwd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !clr_q) begin
      fwd_addr_q <= wr_addr_i;
      fwd_data_q <= wr_data_i;
    end
  end

  // Storage: one write, one registered read (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
      raddr_q <= rd_addr_i;
    end
  end

  assign rd_data_o  = (fwd_v_q && (fwd_addr_q == raddr_q)) ? fwd_data_q : rdata_q;
  assign clr_busy_o = clr_q;

endmodule

[rtl/event_refractory_filter_core.sv]
// Refractory filter: an accepted item is registered in the compare stage, then
// in the output register. One item per cycle while the output is not stalled,
// set by one read-modify-write per item on the timestamp memory (forwarding register).
// Async reset loads config defaults and clears control registers, then a
// clearing pass over all 2**(PixAw+1) entries (131072 by default) zeroes the memory
// with s_axis_tready low; config writes are taken throughout.
module event_refractory_filter_core #(
  parameter int unsigned PixAw = erf_pkg::PixW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [erf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [erf_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input events
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: pix_x[7:0], pix_y[15:8], polarity[16], stamp_us[48:17], zero pad
  input  logic [erf_pkg::TDataW-1:0]    s_axis_tdata,
  // Passed events
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: out_x[7:0], out_y[15:8], out_polarity[16], out_stamp_us[48:17], zero pad
  output logic [erf_pkg::TDataW-1:0]    m_axis_tdata
);

  localparam int unsigned SlotW = PixAw + 1;
  localparam int unsigned LinW  = (PixAw > 17) ? PixAw : 17;

  // Config registers
  logic [erf_pkg::StampW-1:0] period_q;
  logic                       per_pol_q;
  logic [erf_pkg::RowW-1:0]   row_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= erf_pkg::PeriodRst;
      per_pol_q   <= erf_pkg::PerPolRst;
      row_width_q <= erf_pkg::RowWidthRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (erf_pkg::cfg_idx_e'(cfg_index_i))
        erf_pkg::CfgPeriod:   period_q    <= cfg_data_i;
        erf_pkg::CfgPerPol:   per_pol_q   <= cfg_data_i[0];
        erf_pkg::CfgRowWidth: row_width_q <= cfg_data_i[erf_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  // Slot address of the incoming item
  erf_pkg::event_t  ev_in;
  logic [LinW-1:0]  lin;
  logic [SlotW-1:0] slot;
  logic             in_acc;
  logic             clr_busy;

  assign ev_in  = erf_pkg::event_t'(s_axis_tdata[erf_pkg::EvW-1:0]);
  assign lin    = LinW'(ev_in.y) * LinW'(row_width_q) + LinW'(ev_in.x);
  assign slot   = {lin[PixAw-1:0], per_pol_q & ev_in.pol};
  assign in_acc = s_axis_tvalid & s_axis_tready;

  // Compare stage: item waits here for its stored time
  logic                       s1_v_q, s1_v_d;
  erf_pkg::event_t            s1_ev_q;
  logic [SlotW-1:0]           s1_slot_q;
  logic [erf_pkg::StampW-1:0] last_time;
  logic [erf_pkg::StampW:0]   diff;
  logic                       pass;
  logic                       adv;
  logic                       wr_en;

  logic                       out_v_q, out_v_d;
  erf_pkg::event_t            out_ev_q;

  // Signed 33-bit difference; negative always drops
  assign diff  = {1'b0, s1_ev_q.stamp} - {1'b0, last_time};
  assign pass  = !diff[erf_pkg::StampW] && (diff[erf_pkg::StampW-1:0] >= period_q);
  assign adv   = !pass || !out_v_q || m_axis_tready;
  assign wr_en = s1_v_q && pass && adv;

  assign s_axis_tready = !clr_busy && (!s1_v_q || adv);

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_acc) begin
      s1_v_d = 1'b1;
    end else if (adv) begin
      s1_v_d = 1'b0;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (wr_en) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ev_q   <= ev_in;
      s1_slot_q <= slot;
    end
    if (wr_en) begin
      out_ev_q <= s1_ev_q;
    end
  end

  // Last-time store
  erf_ts_mem #(
    .AddrW (SlotW)
  ) u_ts_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_acc),
    .rd_addr_i  (slot),
    .rd_data_o  (last_time),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s1_slot_q),
    .wr_data_i  (s1_ev_q.stamp),
    .clr_busy_o (clr_busy)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{erf_pkg::PadW{1'b0}}, out_ev_q};

endmodule

[rtl/erf_checker.sv]
module erf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [erf_pkg::TDataW-1:0] s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [erf_pkg::TDataW-1:0] m_axis_tdata
);

  // Held item stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // Output goes low only after the item was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("output item lost");

  // A fresh output carries, unchanged, an accepted item passed through the compare stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready, 2) && (m_axis_tdata == $past(s_axis_tdata, 2)))
    else $error("output item without matching input item");

  // Memory clearing holds off input right after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !s_axis_tready)
    else $error("input taken before store clear");

endmodule

bind event_refractory_filter_core erf_checker u_erf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
